[hdl/scsa_pkg.sv]
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, codes and helpers for the size-class slot allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int SIZE_W    = 16;
  localparam int CLS_W     = 4;
  localparam int SLOT_W    = 7;
  localparam int STATUS_W  = 3;
  localparam int MAX_SLOTS = 128;
  localparam int CNT_W     = 8;
  localparam int LEN_W     = 5;

  localparam logic [CLS_W-1:0] TOP_CLASS = 4'd12;

  // command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLASS_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_POOLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REL_IGNORE = 3'd4;

  // classified operation kinds
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_REFUSE  = 2'd1;
  localparam logic [1:0] OP_REL     = 2'd2;
  localparam logic [1:0] OP_REL_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } op_t;

  typedef struct packed {
    logic                granted;
    logic [CLS_W-1:0]    cls;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } result_t;

  // slot count of a class, from the per-group counts
  function automatic logic [CNT_W-1:0] slot_count(
    input logic [CLS_W-1:0] cls,
    input int               n_small,
    input int               n_1k,
    input int               n_2k,
    input int               n_4k
  );
    logic [CNT_W-1:0] n;
    if (cls < 4'd10) n = CNT_W'(n_small);
    else if (cls == 4'd10) n = CNT_W'(n_1k);
    else if (cls == 4'd11) n = CNT_W'(n_2k);
    else n = CNT_W'(n_4k);
    return n;
  endfunction

  // flags whose index has bit b set, for one-hot to binary encoding
  function automatic logic [MAX_SLOTS-1:0] enc_mask(input int b);
    logic [MAX_SLOTS-1:0] m;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      m[i] = ((i >> b) & 1) == 1;
    end
    return m;
  endfunction

endpackage

[hdl/scsa_fifo.sv]
// ----------------------------------------------------------------------------
// scsa_fifo
// Two-entry register queue used between the allocator stages.
// ----------------------------------------------------------------------------
module scsa_fifo #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int CNT_W = 2;

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

endmodule

[hdl/scsa_front.sv]
// ----------------------------------------------------------------------------
// scsa_front
// Accepts requests, holds the pool limit and classifies each request.
// ----------------------------------------------------------------------------
module scsa_front import scsa_pkg::*; #(
  parameter int SLOTS_SMALL = 32,
  parameter int SLOTS_1K    = 64,
  parameter int SLOTS_2K    = 128,
  parameter int SLOTS_4K    = 32,
  parameter int NUM_CLASSES = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CLS_W-1:0]  cfg_wdata,
  input  logic              cmd,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [CLS_W-1:0]  rel_class,
  input  logic [SLOT_W-1:0] rel_slot,
  output op_t               op
);

  logic [CLS_W-1:0]  max_pooled_log2;
  logic [SIZE_W-1:0] size_m1;
  logic [LEN_W-1:0]  len;
  logic              refuse;
  logic              rel_ok;
  logic [CNT_W-1:0]  rel_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_pooled_log2 <= TOP_CLASS;
    end else if (cfg_we) begin
      max_pooled_log2 <= cfg_wdata;
    end
  end

  // class is the bit length of size - 1
  always_comb begin
    size_m1 = req_size - 1'b1;
    len     = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size_m1[i]) len = LEN_W'(i + 1);
    end
  end

  assign refuse = (req_size == '0) || (len > {1'b0, max_pooled_log2}) ||
                  (len > {1'b0, TOP_CLASS}) || (len >= LEN_W'(NUM_CLASSES));

  assign rel_cnt = slot_count(rel_class, SLOTS_SMALL, SLOTS_1K, SLOTS_2K, SLOTS_4K);
  assign rel_ok  = (rel_class <= TOP_CLASS) && ({1'b0, rel_class} < LEN_W'(NUM_CLASSES)) &&
                   ({1'b0, rel_slot} < rel_cnt);

  always_comb begin
    if (cmd == CMD_RELEASE) begin
      op.kind = rel_ok ? OP_REL : OP_REL_BAD;
      op.cls  = rel_class;
      op.slot = rel_slot;
    end else begin
      op.kind = refuse ? OP_REFUSE : OP_ALLOC;
      op.cls  = refuse ? '0 : len[CLS_W-1:0];
      op.slot = '0;
    end
  end

endmodule

[hdl/scsa_back.sv]
// ----------------------------------------------------------------------------
// scsa_back
// Holds busy-flag maps; does one classified request per cycle unless res_full.
// ----------------------------------------------------------------------------
module scsa_back import scsa_pkg::*; #(
  parameter int SLOTS_SMALL = 32,
  parameter int SLOTS_1K    = 64,
  parameter int SLOTS_2K    = 128,
  parameter int SLOTS_4K    = 32,
  parameter int NUM_CLASSES = 13
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  input  op_t     op,
  output logic    op_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [MAX_SLOTS-1:0] busy [NUM_CLASSES];
  logic [CIDX_W-1:0]    idx;
  logic [MAX_SLOTS-1:0] flags;
  logic [MAX_SLOTS-1:0] avail;
  logic [MAX_SLOTS-1:0] lowest;
  logic [MAX_SLOTS-1:0] rel_bit;
  logic [CNT_W-1:0]     cnt;
  logic [SLOT_W-1:0]    free_slot;
  logic                 found;
  logic                 fire;
  logic                 rel_busy;

  assign fire     = op_valid && !res_full;
  assign op_pop   = fire;
  assign res_push = fire;

  assign idx   = ({1'b0, op.cls} < (CLS_W + 1)'(NUM_CLASSES)) ? CIDX_W'(op.cls) : '0;
  assign flags = busy[idx];
  assign cnt   = slot_count(op.cls, SLOTS_SMALL, SLOTS_1K, SLOTS_2K, SLOTS_4K);

  // lowest free slot: isolate the lowest set bit, then encode it
  assign avail  = ~flags & ~({MAX_SLOTS{1'b1}} << cnt);
  assign lowest = avail & (~avail + 1'b1);
  assign found  = |avail;

  always_comb begin
    for (int b = 0; b < SLOT_W; b++) begin
      free_slot[b] = |(lowest & enc_mask(b));
    end
  end

  assign rel_bit  = MAX_SLOTS'(1) << op.slot;
  assign rel_busy = flags[op.slot];

  always_comb begin
    res.granted = 1'b0;
    res.cls     = op.cls;
    res.slot    = op.slot;
    res.status  = ST_REL_IGNORE;
    unique case (op.kind)
      OP_ALLOC: begin
        res.granted = found;
        res.slot    = found ? free_slot : '0;
        res.status  = found ? ST_ALLOCATED : ST_CLASS_FULL;
      end
      OP_REFUSE: begin
        res.cls    = '0;
        res.slot   = '0;
        res.status = ST_NOT_POOLED;
      end
      OP_REL: begin
        res.status = rel_busy ? ST_RELEASED : ST_REL_IGNORE;
      end
      OP_REL_BAD: begin
        res.status = ST_REL_IGNORE;
      end
      default: begin
        res.status = ST_REL_IGNORE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        busy[c] <= '0;
      end
    end else if (fire) begin
      if (op.kind == OP_ALLOC && found) begin
        busy[idx] <= flags | lowest;
      end else if (op.kind == OP_REL && rel_busy) begin
        busy[idx] <= flags & ~rel_bit;
      end
    end
  end

endmodule

[hdl/size_class_slot_allocator.sv]
// ----------------------------------------------------------------------------
// size_class_slot_allocator
// Power-of-two size-class slot allocator with per-class busy-flag maps.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port (push/full) and results leave
// through another (empty/pop), one result per request, in order. The block
// sustains one request per clock unless the result queue is full: the back
// stage does a class map's flag lookup and lowest-free search combinationally
// and registers its flag update; that read-modify-write of the busy maps sets
// the rate. A request passes the request queue, then the result queue, before
// its result shows on the result ports. Two-entry queues on both sides of the
// back stage let either side stall without stopping the other. The user must
// write the pool limit register (cfg_we/cfg_wdata) only while the block is
// idle; the block itself does not enforce this.
module size_class_slot_allocator import scsa_pkg::*; #(
  parameter int SLOTS_SMALL = 32,
  parameter int SLOTS_1K    = 64,
  parameter int SLOTS_2K    = 128,
  parameter int SLOTS_4K    = 32,
  parameter int NUM_CLASSES = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CLS_W-1:0]    cfg_wdata,
  input  logic                push,
  output logic                full,
  input  logic                cmd,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [CLS_W-1:0]    rel_class,
  input  logic [SLOT_W-1:0]   rel_slot,
  output logic                empty,
  input  logic                pop,
  output logic                granted,
  output logic [CLS_W-1:0]    class_index,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [STATUS_W-1:0] status
);

  op_t     op_in;
  op_t     op_q;
  logic    op_empty;
  logic    op_pop;
  logic    res_full;
  logic    res_push;
  result_t res_d;
  result_t res_q;

  scsa_front #(
    .SLOTS_SMALL (SLOTS_SMALL),
    .SLOTS_1K    (SLOTS_1K),
    .SLOTS_2K    (SLOTS_2K),
    .SLOTS_4K    (SLOTS_4K),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .req_size  (req_size),
    .rel_class (rel_class),
    .rel_slot  (rel_slot),
    .op        (op_in)
  );

  scsa_fifo #(
    .WIDTH ($bits(op_t))
  ) u_op_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (op_in),
    .full  (full),
    .pop   (op_pop),
    .dout  (op_q),
    .empty (op_empty)
  );

  scsa_back #(
    .SLOTS_SMALL (SLOTS_SMALL),
    .SLOTS_1K    (SLOTS_1K),
    .SLOTS_2K    (SLOTS_2K),
    .SLOTS_4K    (SLOTS_4K),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!op_empty),
    .op       (op_q),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_d)
  );

  scsa_fifo #(
    .WIDTH ($bits(result_t))
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_d),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  assign granted     = res_q.granted;
  assign class_index = res_q.cls;
  assign slot_index  = res_q.slot;
  assign status      = res_q.status;

  // an accepted beat is waiting for the back stage on the next cycle
  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !op_empty)
    else $error("accepted request not queued");

  // a back-stage result always lands in the result queue
  a_result_queued: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !empty)
    else $error("result lost");

  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (granted == (status == ST_ALLOCATED)))
    else $error("granted flag disagrees with status");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_NOT_POOLED) |-> (class_index == '0 && slot_index == '0))
    else $error("refused request carries a class or slot");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the size-class slot allocator. A clocked
// driver offers allocate and release beats from a backlog queue and predicts
// each accepted beat against its own copy of the busy maps and pool limit.
// A clocked monitor pops results and compares them field by field. Phases
// step through pool-limit settings and idle/stall mixes, with one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench import scsa_pkg::*; ();

  localparam int TOP_CLS    = 12;
  localparam int HOLD_LEN   = 200;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_PHASES   = 8;
  localparam int PHASE_LEN  = 135;

  typedef struct {
    logic              cmd;
    logic [SIZE_W-1:0] size;
    logic [CLS_W-1:0]  rcls;
    logic [SLOT_W-1:0] rslot;
  } request_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CLS_W-1:0]    cfg_wdata = '0;
  logic                push = 1'b0;
  logic                full;
  logic                cmd = CMD_ALLOC;
  logic [SIZE_W-1:0]   req_size = '0;
  logic [CLS_W-1:0]    rel_class = '0;
  logic [SLOT_W-1:0]   rel_slot = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic                granted;
  logic [CLS_W-1:0]    class_index;
  logic [SLOT_W-1:0]   slot_index;
  logic [STATUS_W-1:0] status;

  size_class_slot_allocator uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .req_size    (req_size),
    .rel_class   (rel_class),
    .rel_slot    (rel_slot),
    .empty       (empty),
    .pop         (pop),
    .granted     (granted),
    .class_index (class_index),
    .slot_index  (slot_index),
    .status      (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: one busy map per class, plus the pool limit
  logic [MAX_SLOTS-1:0] slot_busy [0:TOP_CLS];
  logic [CLS_W-1:0]     pool_limit = TOP_CLASS;

  request_t request_backlog [$];
  result_t  pending_outcomes [$];
  request_t offer;
  result_t  predicted;
  result_t  seen;
  result_t  want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int status_tally [0:7];
  int idle_cycles = 0;
  int hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_active;

  assign hold_active = hold_req && (hold_cnt < HOLD_LEN);

  function automatic int class_slots(input int c);
    if (c < 10) return 32;
    if (c == 10) return 64;
    if (c == 11) return 128;
    return 32;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // apply one request to the predictor state and return its result
  task automatic serve_request(input request_t r, output result_t res);
    int c;
    int n;
    bit found;
    res = '{granted: 1'b0, cls: '0, slot: '0, status: ST_REL_IGNORE};
    if (r.cmd == CMD_ALLOC) begin
      c = 0;
      while (c < 16 && (1 << c) < int'(r.size)) c++;
      if (r.size == 0 || c > int'(pool_limit) || c > TOP_CLS) begin
        res.status = ST_NOT_POOLED;
      end else begin
        n = class_slots(c);
        found = 1'b0;
        res.cls = CLS_W'(c);
        res.status = ST_CLASS_FULL;
        for (int s = 0; s < n; s++) begin
          if (!found && !slot_busy[c][s]) begin
            found = 1'b1;
            slot_busy[c][s] = 1'b1;
            res.granted = 1'b1;
            res.slot = SLOT_W'(s);
            res.status = ST_ALLOCATED;
          end
        end
      end
    end else begin
      res.cls = r.rcls;
      res.slot = r.rslot;
      if (int'(r.rcls) <= TOP_CLS && int'(r.rslot) < class_slots(int'(r.rcls))) begin
        if (slot_busy[r.rcls][r.rslot]) begin
          slot_busy[r.rcls][r.rslot] = 1'b0;
          res.status = ST_RELEASED;
        end
      end
    end
  endtask

  // driver: predict the beat just accepted, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        serve_request(offer, predicted);
        pending_outcomes.push_back(predicted);
        items_sent++;
      end
      if (!push || !full) begin
        if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offer = request_backlog.pop_front();
          cmd <= offer.cmd;
          req_size <= offer.size;
          rel_class <= offer.rcls;
          rel_slot <= offer.rslot;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: check the popped beat against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen = '{granted: granted, cls: class_index, slot: slot_index, status: status};
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = pending_outcomes.pop_front();
          status_tally[want.status]++;
          if (seen.granted !== want.granted)
            flag_mismatch($sformatf("granted %0b, want %0b", seen.granted, want.granted));
          if (seen.cls !== want.cls)
            flag_mismatch($sformatf("class_index %0d, want %0d", seen.cls, want.cls));
          if (seen.slot !== want.slot)
            flag_mismatch($sformatf("slot_index %0d, want %0d", seen.slot, want.slot));
          if (seen.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", seen.status, want.status));
        end
      end
      if (hold_active) pop <= 1'b0;
      else pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!hold_req) hold_cnt <= 0;
    else if (hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("size_class_slot_allocator regression: fail");
      $finish;
    end
  end

  function automatic request_t random_request();
    request_t r;
    r.cmd = 1'($urandom_range(0, 1));
    r.size = SIZE_W'($urandom_range(0, 65535));
    r.rcls = CLS_W'($urandom_range(0, 15));
    r.rslot = SLOT_W'($urandom_range(0, 127));
    return r;
  endfunction

  task automatic add_alloc_size(input int sz);
    request_t r;
    r = random_request();
    r.cmd = CMD_ALLOC;
    r.size = SIZE_W'(sz);
    request_backlog.push_back(r);
  endtask

  task automatic add_alloc_class(input int c);
    if (c == 0) add_alloc_size(1);
    else add_alloc_size($urandom_range((1 << (c - 1)) + 1, 1 << c));
  endtask

  task automatic add_release(input int c, input int s);
    request_t r;
    r = random_request();
    r.cmd = CMD_RELEASE;
    r.rcls = CLS_W'(c);
    r.rslot = SLOT_W'(s);
    request_backlog.push_back(r);
  endtask

  task automatic drain();
    while (request_backlog.size() != 0 || push || pending_outcomes.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  int phase_limit [0:N_PHASES-1] = '{12, 0, 15, 6, 11, 12, 13, 10};
  int n_gen;
  int pick;
  int c_sel;
  int len;

  initial begin
    for (int i = 0; i < 8; i++) status_tally[i] = 0;
    for (int c = 0; c <= TOP_CLS; c++) slot_busy[c] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      @(negedge clk);
      if (p > 0) begin
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= CLS_W'(phase_limit[p]);
        @(posedge clk);
        cfg_we <= 1'b0;
        pool_limit = CLS_W'(phase_limit[p]);
        @(negedge clk);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (p == 2) hold_req = 1'b1;

      if (p == 0) begin
        // edge sizes, rounding, bad and free releases
        add_alloc_size(0);
        add_alloc_size(1);
        add_alloc_size(2);
        add_alloc_size(3);
        add_alloc_size(4096);
        add_alloc_size(4097);
        add_alloc_size(65535);
        add_alloc_size(32768);
        add_alloc_size(1024);
        add_alloc_size(1025);
        add_release(0, 0);
        add_release(0, 0);
        add_release(13, 0);
        add_release(15, 127);
        add_release(0, 32);
        add_release(11, 127);
        add_release(12, 32);
        add_release(10, 64);
        add_release(11, 0);
        add_alloc_size(513);
      end

      n_gen = 0;
      while (n_gen < PHASE_LEN) begin
        pick = $urandom_range(0, 99);
        c_sel = $urandom_range(0, TOP_CLS);
        if (pick < 4) begin
          // fill a class past its end, then free about half of it
          len = class_slots(c_sel) + $urandom_range(1, 4);
          for (int k = 0; k < len; k++) add_alloc_class(c_sel);
          for (int k = 0; k < class_slots(c_sel) / 2; k++)
            add_release(c_sel, $urandom_range(0, class_slots(c_sel) - 1));
          n_gen += len + class_slots(c_sel) / 2;
        end else if (pick < 50) begin
          add_alloc_class(c_sel);
          n_gen++;
        end else if (pick < 85) begin
          if ($urandom_range(0, 1)) add_release(c_sel, $urandom_range(0, class_slots(c_sel) - 1));
          else add_release(c_sel, $urandom_range(0, 7));
          n_gen++;
        end else begin
          request_backlog.push_back(random_request());
          n_gen++;
        end
      end
      drain();
      hold_req = 1'b0;
    end

    repeat (10) @(negedge clk);
    if (pending_outcomes.size() != 0) flag_mismatch("expected results never arrived");
    $display("covered %0d requests over %0d pool-limit phases, %0d results checked",
             items_sent, N_PHASES, results_seen);
    $display("granted %0d, class full %0d, not pooled %0d, released %0d, ignored %0d",
             status_tally[ST_ALLOCATED], status_tally[ST_CLASS_FULL],
             status_tally[ST_NOT_POOLED], status_tally[ST_RELEASED],
             status_tally[ST_REL_IGNORE]);
    if (mismatch_count == 0) begin
      $display("size_class_slot_allocator regression: pass");
    end else begin
      $display("size_class_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule
